@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the height grid block.
// Depends on nothing; the using module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hgn_pkg.sv @@
// Package for the height grid neighbour query block: types, codes and widths.
// Used by every module of the block but hgn_height_mem; depends on nothing.
package hgn_pkg;

  localparam int unsigned COORD_W    = 6;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned IN_HEIGHT_W = 16;
  localparam int unsigned THRESH_W   = 16;
  localparam int unsigned MASK_W     = 4;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned S_TDATA_W  = 32;
  localparam int unsigned M_TDATA_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0]    GRID_WIDTH_RESET = 7'd64;
  localparam logic [DIM_W-1:0]    GRID_DEPTH_RESET = 7'd64;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 16'd0;

  // Item commands, carried on s_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Read steps of a query: the centre first, then the neighbours.
  localparam logic [STEP_W-1:0] STEP_CENTRE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LEFT   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RIGHT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOWER  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_UPPER  = 3'd4;

  // Neighbour bit positions in the mask.
  localparam int unsigned NB_LEFT  = 0;
  localparam int unsigned NB_RIGHT = 1;
  localparam int unsigned NB_LOWER = 2;
  localparam int unsigned NB_UPPER = 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       load_centre;
    logic       compare;
    logic [1:0] idx;
  } slope_ctrl_t;

endpackage

@@ rtl/hgn_height_mem.sv @@
// Single-port height memory with registered read data.
// Depends on nothing; instantiated by height_grid_neighbour_query.
module hgn_height_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

@@ rtl/hgn_slope_unit.sv @@
// Shared slope unit: holds the centre height, compares one neighbour per cycle
// and accumulates the neighbour mask and count. Depends on hgn_pkg.
module hgn_slope_unit #(
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic                          clk,
  input  hgn_pkg::slope_ctrl_t          ctrl,
  input  logic [hgn_pkg::MASK_W-1:0]    nb_ok,
  input  logic [hgn_pkg::THRESH_W-1:0]  threshold,
  input  logic [HEIGHT_BITS-1:0]        rd_data,
  output logic [hgn_pkg::MASK_W-1:0]    mask,
  output logic [hgn_pkg::COUNT_W-1:0]   count
);

  localparam int unsigned CMP_W = HEIGHT_BITS + hgn_pkg::THRESH_W + 1;

  logic [HEIGHT_BITS-1:0] centre;
  logic signed [HEIGHT_BITS:0] diff;
  logic [HEIGHT_BITS:0] mag;
  logic in_limit;
  logic take;

  // Heights are two's complement; one extra bit keeps the difference exact.
  always_comb begin
    diff = $signed({centre[HEIGHT_BITS-1], centre})
         - $signed({rd_data[HEIGHT_BITS-1], rd_data});
    mag = diff[HEIGHT_BITS] ? (HEIGHT_BITS+1)'(-diff) : (HEIGHT_BITS+1)'(diff);
    in_limit = CMP_W'(mag) <= CMP_W'(threshold);
    take = ctrl.compare && nb_ok[ctrl.idx] && in_limit;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_centre) begin
      centre <= rd_data;
    end
    if (ctrl.clear) begin
      mask  <= '0;
      count <= '0;
    end else if (take) begin
      mask[ctrl.idx] <= 1'b1;
      count          <= count + hgn_pkg::COUNT_W'(1);
    end
  end

endmodule

@@ rtl/height_grid_neighbour_query.sv @@
// Height grid neighbour query: a height map with a four-neighbour slope query.
// Channels: s_* carries items in (tuser = command, 0 write, 1 query); m_* carries
// one result per query (mask and count in tdata, position_ok in tuser). Writes
// give no result. The cfg_* port writes grid_width, grid_depth and
// slope_threshold at any time; it is meant to be used while the block is idle.
// After reset the block sweeps the height memory to zero, one entry a cycle,
// MAX_WIDTH * MAX_DEPTH entries (4096 by default), and s_tready stays low until
// the sweep is done; configuration writes are taken during the sweep.
// A write passes through ST_ADDR and ST_WRITE before the next item is taken.
// A query inside the grid passes through ST_ADDR, ST_READ, ST_LAST and ST_DONE,
// where its result is loaded into the output register; a query outside the grid
// goes from ST_ADDR straight to ST_DONE. The query time is set by the five reads (centre and
// four neighbours) through the single port of the height memory, one per cycle.
// A finished result waits in the output register; the block accepts further
// items meanwhile and only holds a later query result until m_tready frees it.
// Depends on hgn_pkg, hgn_height_mem and hgn_slope_unit.
module height_grid_neighbour_query #(
  parameter int unsigned MAX_WIDTH   = 64,
  parameter int unsigned MAX_DEPTH   = 64,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: col_x [5:0], row_y [11:6], height_value [27:12], zero [31:28]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hgn_pkg::S_TDATA_W-1:0]     s_tdata,
  // s_tuser: command [0]
  input  logic                              s_tuser,
  // m_tdata: neighbour_mask [3:0], neighbour_count [6:4], zero [7]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [hgn_pkg::M_TDATA_W-1:0]     m_tdata,
  // m_tuser: position_ok [0]
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [hgn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hgn_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned STORE_SIZE = MAX_WIDTH * MAX_DEPTH;
  localparam int unsigned ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned WCAP       = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
  localparam int unsigned DCAP       = (MAX_DEPTH > 127) ? 127 : MAX_DEPTH;
  localparam int unsigned LIN_W      = 14;
  localparam int unsigned SUM_W      = ADDR_W + 8;

  localparam int unsigned CW = hgn_pkg::COORD_W;
  localparam int unsigned DW = hgn_pkg::DIM_W;

  hgn_pkg::state_t state, state_next;

  // Configuration registers.
  logic [DW-1:0]                  grid_width;
  logic [DW-1:0]                  grid_depth;
  logic [hgn_pkg::THRESH_W-1:0]   slope_threshold;

  // Item registers.
  logic                           cmd;
  logic [CW-1:0]                  col_x;
  logic [CW-1:0]                  row_y;
  logic [hgn_pkg::IN_HEIGHT_W-1:0] height_value;

  logic [ADDR_W-1:0]              clr_cnt;
  logic [ADDR_W-1:0]              centre_addr;
  logic [hgn_pkg::MASK_W-1:0]     nb_ok;
  logic                           pos_ok;
  logic [hgn_pkg::STEP_W-1:0]     step;
  logic [hgn_pkg::STEP_W-1:0]     rd_step;
  logic                           rd_live;

  logic [DW-1:0]                  eff_w;
  logic [DW-1:0]                  eff_d;
  logic                           cell_ok;
  logic [hgn_pkg::MASK_W-1:0]     nb_ok_now;
  logic [LIN_W-1:0]               lin;
  logic [ADDR_W+LIN_W-1:0]        lin_ext;
  logic [SUM_W-1:0]               nb_operand;
  logic                           nb_sub;
  logic [SUM_W-1:0]               nb_sum;
  logic                           clr_done;
  logic                           load_out;

  logic                           mem_en;
  logic                           mem_we;
  logic [ADDR_W-1:0]              mem_addr;
  logic [HEIGHT_BITS-1:0]         mem_wdata;
  logic [HEIGHT_BITS-1:0]         mem_rdata;
  logic [HEIGHT_BITS+hgn_pkg::IN_HEIGHT_W-1:0] height_ext;

  hgn_pkg::slope_ctrl_t           slope_ctrl;
  logic [hgn_pkg::MASK_W-1:0]     slope_mask;
  logic [hgn_pkg::COUNT_W-1:0]    slope_count;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width      <= hgn_pkg::GRID_WIDTH_RESET;
      grid_depth      <= hgn_pkg::GRID_DEPTH_RESET;
      slope_threshold <= hgn_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hgn_pkg::CFG_GRID_WIDTH:      grid_width      <= cfg_data[DW-1:0];
        hgn_pkg::CFG_GRID_DEPTH:      grid_depth      <= cfg_data[DW-1:0];
        hgn_pkg::CFG_SLOPE_THRESHOLD: slope_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Bounds and the linear cell address.
  always_comb begin
    eff_w = (grid_width > DW'(WCAP)) ? DW'(WCAP) : grid_width;
    eff_d = (grid_depth > DW'(DCAP)) ? DW'(DCAP) : grid_depth;
    cell_ok = ({1'b0, col_x} < eff_w) && ({1'b0, row_y} < eff_d);
    nb_ok_now[hgn_pkg::NB_LEFT]  = cell_ok && (col_x != '0);
    nb_ok_now[hgn_pkg::NB_RIGHT] = cell_ok && ((DW'(col_x) + DW'(1)) < eff_w);
    nb_ok_now[hgn_pkg::NB_LOWER] = cell_ok && (row_y != '0);
    nb_ok_now[hgn_pkg::NB_UPPER] = cell_ok && ((DW'(row_y) + DW'(1)) < eff_d);
    lin = LIN_W'(row_y) * LIN_W'(eff_w) + LIN_W'(col_x);
    lin_ext = (ADDR_W+LIN_W)'(lin);
  end

  // Shared address adder: the centre address plus or minus one or a row.
  always_comb begin
    nb_sub = (step == hgn_pkg::STEP_LEFT) || (step == hgn_pkg::STEP_LOWER);
    if ((step == hgn_pkg::STEP_LEFT) || (step == hgn_pkg::STEP_RIGHT)) begin
      nb_operand = SUM_W'(1);
    end else begin
      nb_operand = SUM_W'(eff_w);
    end
    nb_sum = nb_sub ? (SUM_W'(centre_addr) - nb_operand)
                    : (SUM_W'(centre_addr) + nb_operand);
  end

  assign clr_done   = (clr_cnt == ADDR_W'(STORE_SIZE - 1));
  assign height_ext = (HEIGHT_BITS+hgn_pkg::IN_HEIGHT_W)'(height_value);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hgn_pkg::ST_CLEAR: if (clr_done) state_next = hgn_pkg::ST_IDLE;
      hgn_pkg::ST_IDLE:  if (s_tvalid) state_next = hgn_pkg::ST_ADDR;
      hgn_pkg::ST_ADDR: begin
        if (cmd == hgn_pkg::CMD_WRITE) begin
          state_next = hgn_pkg::ST_WRITE;
        end else if (cell_ok) begin
          state_next = hgn_pkg::ST_READ;
        end else begin
          state_next = hgn_pkg::ST_DONE;
        end
      end
      hgn_pkg::ST_WRITE: state_next = hgn_pkg::ST_IDLE;
      hgn_pkg::ST_READ:  if (step == hgn_pkg::STEP_UPPER) state_next = hgn_pkg::ST_LAST;
      hgn_pkg::ST_LAST:  state_next = hgn_pkg::ST_DONE;
      hgn_pkg::ST_DONE:  if (!m_tvalid || m_tready) state_next = hgn_pkg::ST_IDLE;
      default:           state_next = hgn_pkg::ST_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready  = 1'b0;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = centre_addr;
    mem_wdata = '0;
    load_out  = 1'b0;
    unique case (state)
      hgn_pkg::ST_CLEAR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = clr_cnt;
      end
      hgn_pkg::ST_IDLE: s_tready = 1'b1;
      hgn_pkg::ST_WRITE: begin
        mem_en    = 1'b1;
        mem_we    = pos_ok;
        mem_wdata = height_ext[HEIGHT_BITS-1:0];
      end
      hgn_pkg::ST_READ: begin
        mem_en = 1'b1;
        // A neighbour outside the grid rereads the centre; its result is masked.
        if (step != hgn_pkg::STEP_CENTRE && nb_ok[2'(step - hgn_pkg::STEP_LEFT)]) begin
          mem_addr = nb_sum[ADDR_W-1:0];
        end
      end
      hgn_pkg::ST_DONE: load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_comb begin
    slope_ctrl.clear       = (state == hgn_pkg::ST_ADDR);
    slope_ctrl.load_centre = rd_live && (rd_step == hgn_pkg::STEP_CENTRE);
    slope_ctrl.compare     = rd_live && (rd_step != hgn_pkg::STEP_CENTRE);
    slope_ctrl.idx         = 2'(rd_step - hgn_pkg::STEP_LEFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= hgn_pkg::ST_CLEAR;
      clr_cnt <= '0;
      step    <= hgn_pkg::STEP_CENTRE;
      rd_live <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= (state == hgn_pkg::ST_READ);
      if (state == hgn_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (state == hgn_pkg::ST_ADDR) begin
        step <= hgn_pkg::STEP_CENTRE;
      end else if (state == hgn_pkg::ST_READ) begin
        step <= step + hgn_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_step <= step;
    if (s_tvalid && s_tready) begin
      cmd          <= s_tuser;
      col_x        <= s_tdata[CW-1:0];
      row_y        <= s_tdata[2*CW-1:CW];
      height_value <= s_tdata[2*CW+hgn_pkg::IN_HEIGHT_W-1:2*CW];
    end
    if (state == hgn_pkg::ST_ADDR) begin
      pos_ok      <= cell_ok;
      nb_ok       <= nb_ok_now;
      centre_addr <= lin_ext[ADDR_W-1:0];
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, slope_count, slope_mask};
      m_tuser <= pos_ok;
    end
  end

  hgn_height_mem #(
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W),
    .DATA_W (HEIGHT_BITS)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  hgn_slope_unit #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_slope (
    .clk       (clk),
    .ctrl      (slope_ctrl),
    .nb_ok     (nb_ok),
    .threshold (slope_threshold),
    .rd_data   (mem_rdata),
    .mask      (slope_mask),
    .count     (slope_count)
  );

endmodule

@@ rtl/hgn_checker.sv @@
// Port-level checker for the height grid neighbour query block, with its bind.
// Depends on hgn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hgn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [hgn_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);

  // Reset starts the clearing sweep: nothing is offered and nothing is taken.
  `ASSERT_CLK_NR(a_reset_quiet, rst |=> !m_tvalid && !s_tready, "busy after reset")

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // The count always agrees with the mask.
  `ASSERT_CLK(a_count_mask, m_tvalid |-> m_tdata[6:4] == 3'($countones(m_tdata[3:0])), "count does not match mask")

  // A query outside the grid accepts no neighbour.
  `ASSERT_CLK(a_outside_empty, m_tvalid && !m_tuser |-> m_tdata[6:0] == 7'd0, "outside query has neighbours")

  // Every transaction keeps the block busy for at least the following cycle.
  `ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready right after a transaction")

endmodule

bind height_grid_neighbour_query hgn_checker u_hgn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
